// File: rtl/gjd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjd_pkg: shared types, constants and tables of the day number converter
// payload structs of both channels, the stage hand-off struct between the
// front and back pipelines, calendar constants and reciprocal multipliers
// ----------------------------------------------------------------------------
package gjd_pkg;

   // field widths
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int JDN_W    = 23;
   localparam int WDAY_W   = 3;

   // internal widths
   localparam int T1_W       = 25;  // 1461 * shifted year
   localparam int CUM_W      = 9;   // day offset of the shifted month
   localparam int CENT_Q_W   = 8;
   localparam int CENT_R_W   = 10;
   localparam int SUM_W      = 25;
   localparam int Q7_W       = 21;
   localparam int X_W        = 24;  // 4 * day count - 1
   localparam int ERA_Q_W    = 7;
   localparam int Z_W        = 18;
   localparam int QUAD_Q_W   = 8;
   localparam int QUAD_R_W   = 11;
   localparam int DOY_W      = 10;
   localparam int SPAN_W     = 12;
   localparam int SPAN_Q_W   = 5;
   localparam int SPAN_R_W   = 8;

   localparam int LANES     = 2;
   localparam int LANE_PREV = 0;
   localparam int LANE_NEXT = 1;

   // calendar constants
   localparam int YEAR_MIN        = 1800;
   localparam int YEAR_MAX        = 9999;
   localparam int MONTH_MIN       = 1;
   localparam int MONTH_MAX       = 12;
   localparam int MONTH_JAN       = 1;
   localparam int MONTH_FEB       = 2;
   localparam int MONTHS_PER_YEAR = 12;
   localparam int MONTH_WRAP      = 10;
   localparam int MARCH_SHIFT     = 3;
   localparam int CENTURY         = 100;
   localparam int EPOCH_YEARS     = 4800;
   localparam int CENT_BIAS       = 4900 / CENTURY;
   localparam int JDN_BIAS        = 32075;
   localparam int JDN_BASE        = 1721119;
   localparam int ERA_DAYS        = 146097;
   localparam int QUAD_DAYS       = 1461;
   localparam int SPAN_DAYS       = 153;
   localparam int WEEK_DAYS       = 7;
   localparam int FIFTH           = 5;

   // reciprocal multipliers: exact floor division for any operand of the
   // stated width, shift = operand width + ceil(log2(divisor))
   localparam int CENT_SH  = 21;  // 14-bit operand
   localparam longint unsigned CENT_MUL =
      ((64'd1 << CENT_SH) + CENTURY - 1) / CENTURY;
   localparam int CENT_MW  = 15;

   localparam int WEEK_SH  = 26;  // 23-bit operand
   localparam longint unsigned WEEK_MUL =
      ((64'd1 << WEEK_SH) + WEEK_DAYS - 1) / WEEK_DAYS;
   localparam int WEEK_MW  = 24;

   localparam int ERA_SH   = 42;  // 24-bit operand
   localparam longint unsigned ERA_MUL =
      ((64'd1 << ERA_SH) + ERA_DAYS - 1) / ERA_DAYS;
   localparam int ERA_MW   = 25;

   localparam int QUAD_SH  = 29;  // 18-bit operand
   localparam longint unsigned QUAD_MUL =
      ((64'd1 << QUAD_SH) + QUAD_DAYS - 1) / QUAD_DAYS;
   localparam int QUAD_MW  = 19;

   localparam int SPAN_SH  = 20;  // 12-bit operand
   localparam longint unsigned SPAN_MUL =
      ((64'd1 << SPAN_SH) + SPAN_DAYS - 1) / SPAN_DAYS;
   localparam int SPAN_MW  = 13;

   localparam int FIFTH_SH = 11;  // 8-bit operand
   localparam longint unsigned FIFTH_MUL =
      ((64'd1 << FIFTH_SH) + FIFTH - 1) / FIFTH;
   localparam int FIFTH_MW = 9;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } gjd_req_type;

   typedef struct packed {
      logic               date_ok;
      logic [JDN_W-1:0]   day_number;
      logic [WDAY_W-1:0]  weekday;
      logic [DAY_W-1:0]   prev_day;
      logic [MONTH_W-1:0] prev_month;
      logic [YEAR_W-1:0]  prev_year;
      logic [DAY_W-1:0]   next_day;
      logic [MONTH_W-1:0] next_month;
      logic [YEAR_W-1:0]  next_year;
   } gjd_rsp_type;

   typedef struct packed {
      logic                       ok;
      logic [JDN_W-1:0]           jdn;
      logic [Q7_W-1:0]            q7;
      logic [LANES-1:0][X_W-1:0]  x;
   } gjd_mid_type;

   // length of a month, february by the leap flag
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] n;
      case (m)
         4'd2: begin
            n = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            n = 5'd30;
         end
         default: begin
            n = 5'd31;
         end
      endcase
      return n;
   endfunction

   // floor(367 * m / 12) for the march-based month 1..12
   function automatic logic [CUM_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
      logic [CUM_W-1:0] n;
      case (m)
         4'd1:    n = 9'd30;
         4'd2:    n = 9'd61;
         4'd3:    n = 9'd91;
         4'd4:    n = 9'd122;
         4'd5:    n = 9'd152;
         4'd6:    n = 9'd183;
         4'd7:    n = 9'd214;
         4'd8:    n = 9'd244;
         4'd9:    n = 9'd275;
         4'd10:   n = 9'd305;
         4'd11:   n = 9'd336;
         4'd12:   n = 9'd367;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

// File: rtl/gjd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjd_front: date check and forward day number, four stages
// input register, term products, validity and day number sum, then the
// weekday quotient and the scaled day counts of the two neighbor dates
// ----------------------------------------------------------------------------
module gjd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  gjd_pkg::gjd_req_type req_payload,
   output logic                 mid_valid,
   input  logic                 mid_stall,
   output gjd_pkg::gjd_mid_type mid_payload
);
   import gjd_pkg::*;

   localparam int STAGES = 4;

   typedef struct packed {
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
      logic [JDN_W-1:0]    t1;
      logic [CUM_W-1:0]    t2;
      logic [CENT_Q_W-1:0] cent_y;
      logic [CENT_Q_W-1:0] cent_a;
   } s1_type;

   typedef struct packed {
      logic             ok;
      logic [JDN_W-1:0] jdn;
   } s2_type;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] adv;

   gjd_req_type s0_ff;
   s1_type      s1_ff;
   s1_type      s1_in;
   s2_type      s2_ff;
   s2_type      s2_in;
   gjd_mid_type s3_ff;
   gjd_mid_type s3_in;

   // stage 1 terms
   logic                         jan_feb;
   logic [YEAR_W-1:0]            year_adj;
   logic [YEAR_W:0]              year_ext;
   logic [T1_W-1:0]              t1_prod;
   logic [MONTH_W-1:0]           month_adj;
   logic [YEAR_W+CENT_MW-1:0]    cent_y_prod;
   logic [YEAR_W+CENT_MW-1:0]    cent_a_prod;

   // stage 2 terms
   logic [YEAR_W-1:0]   year_rem;
   logic                leap;
   logic [CENT_R_W-1:0] cent_sum;
   logic [CENT_R_W-1:0] t3_prod;
   logic [SUM_W-1:0]    jdn_sum;

   // stage 3 terms
   logic [JDN_W+WEEK_MW-1:0] week_prod;
   logic [JDN_W-1:0]         j0;
   logic [JDN_W-1:0]         j_prev;
   logic [JDN_W-1:0]         j_next;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || !mid_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign valid_in  = {valid_ff[STAGES-2:0], req_valid};
   assign req_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_comb begin
      jan_feb   = (s0_ff.month == MONTH_W'(MONTH_JAN)) || (s0_ff.month == MONTH_W'(MONTH_FEB));
      year_adj  = s0_ff.year - YEAR_W'(jan_feb);
      year_ext  = (YEAR_W+1)'(year_adj) + (YEAR_W+1)'(EPOCH_YEARS);
      t1_prod   = T1_W'(year_ext) * T1_W'(QUAD_DAYS);
      // march-based month: jan and feb count as months 11 and 12
      month_adj = jan_feb ? MONTH_W'(s0_ff.month + MONTH_W'(MONTHS_PER_YEAR - 2))
                          : MONTH_W'(s0_ff.month - MONTH_W'(2));
      cent_y_prod = (YEAR_W+CENT_MW)'(s0_ff.year) * (YEAR_W+CENT_MW)'(CENT_MUL);
      cent_a_prod = (YEAR_W+CENT_MW)'(year_adj) * (YEAR_W+CENT_MW)'(CENT_MUL);

      s1_in.day    = s0_ff.day;
      s1_in.month  = s0_ff.month;
      s1_in.year   = s0_ff.year;
      s1_in.t1     = t1_prod[T1_W-1:2];
      s1_in.t2     = month_offset(month_adj);
      s1_in.cent_y = CENT_Q_W'(cent_y_prod >> CENT_SH);
      s1_in.cent_a = CENT_Q_W'(cent_a_prod >> CENT_SH);
   end

   always_comb begin
      year_rem = s1_ff.year - YEAR_W'(s1_ff.cent_y) * YEAR_W'(CENTURY);
      leap     = ((s1_ff.year[1:0] == 2'd0) && (year_rem != '0))
              || ((year_rem == '0) && (s1_ff.cent_y[1:0] == 2'd0));
      cent_sum = CENT_R_W'(s1_ff.cent_a) + CENT_R_W'(CENT_BIAS);
      t3_prod  = CENT_R_W'(cent_sum * CENT_R_W'(3));
      jdn_sum  = SUM_W'(s1_ff.t1) + SUM_W'(s1_ff.t2) - SUM_W'(t3_prod[CENT_R_W-1:2])
               + SUM_W'(s1_ff.day) - SUM_W'(JDN_BIAS);

      s2_in.ok  = (s1_ff.year inside {[YEAR_MIN:YEAR_MAX]})
               && (s1_ff.month inside {[MONTH_MIN:MONTH_MAX]})
               && (s1_ff.day != '0)
               && (s1_ff.day <= month_days(s1_ff.month, leap));
      s2_in.jdn = jdn_sum[JDN_W-1:0];
   end

   always_comb begin
      week_prod = (JDN_W+WEEK_MW)'(s2_ff.jdn) * (JDN_W+WEEK_MW)'(WEEK_MUL);
      j0        = s2_ff.jdn - JDN_W'(JDN_BASE);
      j_prev    = j0 - JDN_W'(1);
      j_next    = j0 + JDN_W'(1);

      s3_in.ok  = s2_ff.ok;
      s3_in.jdn = s2_ff.jdn;
      s3_in.q7  = Q7_W'(week_prod >> WEEK_SH);
      s3_in.x[LANE_PREV] = X_W'({j_prev, 2'b00} - (JDN_W+2)'(1));
      s3_in.x[LANE_NEXT] = X_W'({j_next, 2'b00} - (JDN_W+2)'(1));
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s0_ff <= req_payload;
      end
      if (adv[1]) begin
         s1_ff <= s1_in;
      end
      if (adv[2]) begin
         s2_ff <= s2_in;
      end
      if (adv[3]) begin
         s3_ff <= s3_in;
      end
   end

   assign mid_valid   = valid_ff[STAGES-1];
   assign mid_payload = s3_ff;

endmodule

// File: rtl/gjd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjd_back: inverse conversion of both neighbor dates, seven stages
// two lanes (previous and next day) run side by side through the era,
// four-year and month divisions; the last stage zeroes invalid dates
// ----------------------------------------------------------------------------
module gjd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 mid_valid,
   output logic                 mid_stall,
   input  gjd_pkg::gjd_mid_type mid_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output gjd_pkg::gjd_rsp_type rsp_payload
);
   import gjd_pkg::*;

   localparam int STAGES = 7;
   localparam int SIDE_N = STAGES - 1;

   typedef struct packed {
      logic              ok;
      logic [JDN_W-1:0]  jdn;
      logic [WDAY_W-1:0] wd;
   } side_type;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] adv;

   side_type side_ff [SIDE_N];
   side_type side_in;

   logic [LANES-1:0][X_W-1:0]      a_x_ff;
   logic [LANES-1:0][ERA_Q_W-1:0]  a_yc_ff;
   logic [LANES-1:0][ERA_Q_W-1:0]  a_yc_in;
   logic [LANES-1:0][Z_W-1:0]      b_z_ff;
   logic [LANES-1:0][Z_W-1:0]      b_z_in;
   logic [LANES-1:0][ERA_Q_W-1:0]  b_yc_ff;
   logic [LANES-1:0][Z_W-1:0]      c_z_ff;
   logic [LANES-1:0][ERA_Q_W-1:0]  c_yc_ff;
   logic [LANES-1:0][QUAD_Q_W-1:0] c_jj_ff;
   logic [LANES-1:0][QUAD_Q_W-1:0] c_jj_in;
   logic [LANES-1:0][SPAN_W-1:0]   d_w_ff;
   logic [LANES-1:0][SPAN_W-1:0]   d_w_in;
   logic [LANES-1:0][YEAR_W-1:0]   d_yb_ff;
   logic [LANES-1:0][YEAR_W-1:0]   d_yb_in;
   logic [LANES-1:0][SPAN_W-1:0]   e_w_ff;
   logic [LANES-1:0][SPAN_Q_W-1:0] e_mm_ff;
   logic [LANES-1:0][SPAN_Q_W-1:0] e_mm_in;
   logic [LANES-1:0][YEAR_W-1:0]   e_yb_ff;
   logic [LANES-1:0][SPAN_R_W-1:0] f_dr_ff;
   logic [LANES-1:0][SPAN_R_W-1:0] f_dr_in;
   logic [LANES-1:0][MONTH_W-1:0]  f_mo_ff;
   logic [LANES-1:0][MONTH_W-1:0]  f_mo_in;
   logic [LANES-1:0][YEAR_W-1:0]   f_yr_ff;
   logic [LANES-1:0][YEAR_W-1:0]   f_yr_in;
   logic [LANES-1:0][DAY_W-1:0]    g_dd;

   logic [LANES-1:0][X_W+ERA_MW-1:0]        era_prod;
   logic [LANES-1:0][X_W-1:0]               era_rem;
   logic [LANES-1:0][Z_W+QUAD_MW-1:0]       quad_prod;
   logic [LANES-1:0][QUAD_R_W-1:0]          quad_rem;
   logic [LANES-1:0][DOY_W-1:0]             doy;
   logic [LANES-1:0][SPAN_W+SPAN_MW-1:0]    span_prod;
   logic [LANES-1:0][SPAN_Q_W-1:0]          month_raw;
   logic [LANES-1:0][SPAN_R_W+FIFTH_MW-1:0] fifth_prod;

   gjd_rsp_type out_ff;
   gjd_rsp_type out_in;

   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign valid_in  = {valid_ff[STAGES-2:0], mid_valid};
   assign mid_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // stage a: weekday remainder, era quotient
   always_comb begin
      side_in.ok  = mid_payload.ok;
      side_in.jdn = mid_payload.jdn;
      side_in.wd  = WDAY_W'(mid_payload.jdn - JDN_W'(mid_payload.q7) * JDN_W'(WEEK_DAYS));
      for (int l = 0; l < LANES; l++) begin
         era_prod[l] = (X_W+ERA_MW)'(mid_payload.x[l]) * (X_W+ERA_MW)'(ERA_MUL);
         a_yc_in[l]  = ERA_Q_W'(era_prod[l] >> ERA_SH);
      end
   end

   // stage b: day within era, rounded to 4 * n + 3
   // stage c: four-year quotient
   // stage d: day of year, scaled month count, year base
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         era_rem[l]   = a_x_ff[l] - X_W'(a_yc_ff[l]) * X_W'(ERA_DAYS);
         b_z_in[l]    = {era_rem[l][Z_W-1:2], 2'b11};
         quad_prod[l] = (Z_W+QUAD_MW)'(b_z_ff[l]) * (Z_W+QUAD_MW)'(QUAD_MUL);
         c_jj_in[l]   = QUAD_Q_W'(quad_prod[l] >> QUAD_SH);
         quad_rem[l]  = QUAD_R_W'(c_z_ff[l] - Z_W'(c_jj_ff[l]) * Z_W'(QUAD_DAYS));
         doy[l]       = DOY_W'((SPAN_W'(quad_rem[l]) + SPAN_W'(4)) >> 2);
         d_w_in[l]    = SPAN_W'(SPAN_W'(doy[l]) * SPAN_W'(FIFTH) - SPAN_W'(3));
         d_yb_in[l]   = YEAR_W'(YEAR_W'(c_yc_ff[l]) * YEAR_W'(CENTURY) + YEAR_W'(c_jj_ff[l]));
      end
   end

   // stage e: month quotient
   // stage f: day remainder, month back to january-based with year carry
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         span_prod[l] = (SPAN_W+SPAN_MW)'(d_w_ff[l]) * (SPAN_W+SPAN_MW)'(SPAN_MUL);
         e_mm_in[l]   = SPAN_Q_W'(span_prod[l] >> SPAN_SH);
         f_dr_in[l]   = SPAN_R_W'(e_w_ff[l] - SPAN_W'(e_mm_ff[l]) * SPAN_W'(SPAN_DAYS));
         month_raw[l] = e_mm_ff[l] + SPAN_Q_W'(MARCH_SHIFT);
         if (e_mm_ff[l] < SPAN_Q_W'(MONTH_WRAP)) begin
            f_mo_in[l] = MONTH_W'(month_raw[l]);
            f_yr_in[l] = e_yb_ff[l];
         end else begin
            f_mo_in[l] = MONTH_W'(month_raw[l] - SPAN_Q_W'(MONTHS_PER_YEAR));
            f_yr_in[l] = e_yb_ff[l] + YEAR_W'(1);
         end
      end
   end

   // stage g: day of month, output with invalid dates zeroed
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         fifth_prod[l] = (SPAN_R_W+FIFTH_MW)'(f_dr_ff[l]) * (SPAN_R_W+FIFTH_MW)'(FIFTH_MUL);
         g_dd[l]       = DAY_W'((fifth_prod[l] >> FIFTH_SH) + 1);
      end
      out_in = '0;
      if (side_ff[SIDE_N-1].ok) begin
         out_in.date_ok    = 1'b1;
         out_in.day_number = side_ff[SIDE_N-1].jdn;
         out_in.weekday    = side_ff[SIDE_N-1].wd;
         out_in.prev_day   = g_dd[LANE_PREV];
         out_in.prev_month = f_mo_ff[LANE_PREV];
         out_in.prev_year  = f_yr_ff[LANE_PREV];
         out_in.next_day   = g_dd[LANE_NEXT];
         out_in.next_month = f_mo_ff[LANE_NEXT];
         out_in.next_year  = f_yr_ff[LANE_NEXT];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         side_ff[0] <= side_in;
         a_x_ff     <= mid_payload.x;
         a_yc_ff    <= a_yc_in;
      end
      for (int k = 1; k < SIDE_N; k++) begin
         if (adv[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
      if (adv[1]) begin
         b_z_ff  <= b_z_in;
         b_yc_ff <= a_yc_ff;
      end
      if (adv[2]) begin
         c_z_ff  <= b_z_ff;
         c_yc_ff <= b_yc_ff;
         c_jj_ff <= c_jj_in;
      end
      if (adv[3]) begin
         d_w_ff  <= d_w_in;
         d_yb_ff <= d_yb_in;
      end
      if (adv[4]) begin
         e_w_ff  <= d_w_ff;
         e_mm_ff <= e_mm_in;
         e_yb_ff <= d_yb_ff;
      end
      if (adv[5]) begin
         f_dr_ff <= f_dr_in;
         f_mo_ff <= f_mo_in;
         f_yr_ff <= f_yr_in;
      end
      if (adv[6]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = valid_ff[STAGES-1];
   assign rsp_payload = out_ff;

endmodule

// File: rtl/gregorian_julian_day_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_julian_day_converter: gregorian date to julian day number
// checks the date, gives its day number and weekday and the dates of the
// day before and the day after
//
//   channel  dir  payload        handshake
//   req_     in   gjd_req_type   req_valid / req_stall
//   rsp_     out  gjd_rsp_type   rsp_valid / rsp_stall
//
// one transaction per cycle sustained while the output is not stalled;
// 4 stages in the front (check and day number), 7 in the back (inverse
// conversion, one stage per reciprocal multiply or remainder)
// reset clears the valid bit of every stage, payload registers hold garbage
// a stall holds only the stages that are full, so bubbles close up and the
// input keeps accepting while a result waits in the output register
// ----------------------------------------------------------------------------
module gregorian_julian_day_converter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  gjd_pkg::gjd_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output gjd_pkg::gjd_rsp_type rsp_payload
);
   import gjd_pkg::*;

   logic        mid_valid;
   logic        mid_stall;
   gjd_mid_type mid_payload;

   gjd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .mid_valid   (mid_valid),
      .mid_stall   (mid_stall),
      .mid_payload (mid_payload)
   );

   gjd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .mid_valid   (mid_valid),
      .mid_stall   (mid_stall),
      .mid_payload (mid_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: rtl/gjd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjd_checker: port-level checks of the day number converter
// result hold under stall, reset, zeroed invalid results, sane neighbors
// ----------------------------------------------------------------------------
module gjd_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input gjd_pkg::gjd_rsp_type rsp_payload
);
   import gjd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // first cycle out of reset: pipeline empty, input open
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !req_stall)
      else $error("pipeline not empty right after reset");

   // an invalid date comes back as all zeros
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.date_ok |-> rsp_payload == '0)
      else $error("invalid date with nonzero fields");

   // neighbors of a valid date are real months in order, weekday in range
   a_valid_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.date_ok |->
         rsp_payload.prev_month >= MONTH_W'(MONTH_MIN)
         && rsp_payload.prev_month <= MONTH_W'(MONTH_MAX)
         && rsp_payload.next_month >= MONTH_W'(MONTH_MIN)
         && rsp_payload.next_month <= MONTH_W'(MONTH_MAX)
         && rsp_payload.weekday < WDAY_W'(WEEK_DAYS)
         && rsp_payload.next_year >= rsp_payload.prev_year)
      else $error("neighbor dates out of range");

endmodule

bind gregorian_julian_day_converter gjd_checker u_gjd_checker (.*);
